// ----- rtl/fp64rti_pkg.sv -----
// Package for fp64_round_to_integral: opcodes, field constants, control struct.
// No dependencies.
`default_nettype none
package fp64rti_pkg;
  localparam int unsigned OpW = 3;
  localparam int unsigned DataW = 64;
  localparam logic [10:0] ExpBias = 11'd1023;
  localparam logic [10:0] ExpLarge = 11'd1075;
  localparam logic [63:0] OneBits = 64'h3ff0_0000_0000_0000;
  localparam logic [51:0] MantMask = 52'hf_ffff_ffff_ffff;

  typedef enum logic [2:0] {
    OP_TRUNC  = 3'd0,
    OP_FLOOR  = 3'd1,
    OP_CEIL   = 3'd2,
    OP_HALFAW = 3'd3,
    OP_EVEN   = 3'd4
  } op_e;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;
endpackage
`default_nettype wire

// ----- rtl/fp64rti_core.sv -----
// Combinational rounding datapath of fp64_round_to_integral.
// Depends on fp64rti_pkg.
`default_nettype none
module fp64rti_core import fp64rti_pkg::*; (
  input  logic [OpW-1:0]   opcode_i,
  input  logic [DataW-1:0] operand_i,
  output logic [DataW-1:0] result_o
);
  logic        sign;
  logic [10:0] ef;
  logic [5:0]  e;
  logic [51:0] fmask, frac, half;
  logic [63:0] base;
  logic        nonzero, one, inc, lsb;

  always_comb begin
    sign    = operand_i[63];
    ef      = operand_i[62:52];
    e       = 6'(ef - ExpBias);
    fmask   = MantMask >> e;
    frac    = operand_i[51:0] & fmask;
    half    = (fmask >> 1) + 52'd1;
    base    = operand_i & ~{12'd0, fmask};
    nonzero = operand_i[62:0] != 63'd0;
    lsb     = (e == 6'd0) ? 1'b1 : operand_i[6'd52 - e];
    one = 1'b0;
    inc = 1'b0;
    case (opcode_i)
      OP_FLOOR: begin
        one = sign & nonzero;
        inc = sign;
      end
      OP_CEIL: begin
        one = ~sign & nonzero;
        inc = ~sign;
      end
      OP_HALFAW: begin
        one = ef == ExpBias - 11'd1;
        inc = frac >= half;
      end
      OP_EVEN: begin
        one = (ef == ExpBias - 11'd1) && (operand_i[51:0] != 52'd0);
        inc = (frac > half) || ((frac == half) && lsb);
      end
      default: begin
        one = 1'b0;
        inc = 1'b0;
      end
    endcase
    if (ef >= ExpLarge) begin
      result_o = operand_i;
    end else if (ef < ExpBias) begin
      result_o = one ? ({sign, 63'd0} | OneBits) : {sign, 63'd0};
    end else if (frac == 52'd0) begin
      result_o = operand_i;
    end else begin
      result_o = inc ? base + {11'd0, {1'b0, fmask} + 53'd1} : base;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fp64_round_to_integral.sv -----
// Top level of fp64_round_to_integral: input register, rounding core, output register.
// Depends on fp64rti_pkg and fp64rti_core.
// Path: an accepted input is registered in the input stage, rounded by the core, and
// registered in the result stage; both stages advance together when the result is taken.
// Throughput: one item per cycle while ready_i does not stall the result stage.
// Reset: asynchronous, active low; clears the stage valid flags only.
`default_nettype none
module fp64_round_to_integral import fp64rti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [DataW-1:0] operand_bits_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] result_bits_o
);
  hs_t              in_hs, out_hs;
  logic             in_vld_q, out_vld_q;
  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] opnd_q, res_d, res_q;
  logic             adv_out;

  fp64rti_core u_core (.opcode_i(op_q), .operand_i(opnd_q), .result_o(res_d));

  // advance the result stage when it is empty or being taken
  assign out_hs.valid = out_vld_q;
  assign out_hs.ready = ready_i;
  assign adv_out     = ~out_hs.valid | out_hs.ready;
  assign in_hs.valid = in_vld_q;
  assign in_hs.ready = adv_out | ~in_vld_q;

  assign ready_o       = in_hs.ready;
  assign valid_o       = out_vld_q;
  assign result_bits_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_hs.ready) in_vld_q <= valid_i;
      if (adv_out) out_vld_q <= in_hs.valid;
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_hs.ready && valid_i) begin
      op_q   <= opcode_i;
      opnd_q <= operand_bits_i;
    end
    if (adv_out && in_hs.valid) res_q <= res_d;
  end
endmodule
`default_nettype wire

// ----- rtl/fp64rti_checker.sv -----
// Port-level checker for fp64_round_to_integral, bound to the top level.
// Depends on fp64_round_to_integral.
`default_nettype none
module fp64rti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [63:0] result_bits_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(result_bits_o)) else $error("result dropped");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o) else $error("stalled while empty");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !valid_o |=> ##1 valid_o) else $error("result missing");
endmodule
bind fp64_round_to_integral fp64rti_checker u_chk (.*);
`default_nettype wire

// ----- sim/fp64_round_to_integral_tb.sv -----
// Testbench for fp64_round_to_integral: checks rounded binary64 results against an
// in-bench bit-level rounding predictor under random valid and ready idling.
// Depends on fp64rti_pkg and the fp64_round_to_integral RTL.
`timescale 1ns / 1ps
module fp64_round_to_integral_tb;
  import fp64rti_pkg::*;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [DataW-1:0] operand;
  } round_req_t;

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i;
  logic             ready_o;
  logic [OpW-1:0]   opcode_i;
  logic [DataW-1:0] operand_bits_i;
  logic             valid_o;
  logic             ready_i;
  logic [DataW-1:0] result_bits_o;

  round_req_t       pending_q[$];
  round_req_t       sent_q[$];
  logic [DataW-1:0] rounded_q[$];
  int unsigned      n_mismatch;
  int unsigned      n_checked;
  bit               calm;      // long stretch without idling
  bit               hold_off;  // sender pauses until drained
  bit               feed_done;

  fp64_round_to_integral i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .ready_o        (ready_o),
    .opcode_i       (opcode_i),
    .operand_bits_i (operand_bits_i),
    .valid_o        (valid_o),
    .ready_i        (ready_i),
    .result_bits_o  (result_bits_o)
  );

  // Predict the rounded bit pattern of one operand.
  function automatic logic [63:0] round_integral(logic [2:0] op_raw, logic [63:0] u);
    logic [2:0]  op;
    logic [63:0] sgn;
    logic [10:0] ef;
    int unsigned e;
    logic [63:0] fmask, frac, half, base;
    logic        inc, one, lsb;
    op = op_raw;
    if (op > OP_EVEN) op = OP_TRUNC;
    sgn = u & 64'h8000_0000_0000_0000;
    ef  = u[62:52];
    inc = 1'b0;
    one = 1'b0;
    if (ef >= ExpLarge) return u;
    if (ef < ExpBias) begin
      // below one: a signed zero or a signed unit
      case (op)
        OP_FLOOR:  one = sgn != 0 && u[62:0] != 0;
        OP_CEIL:   one = sgn == 0 && u[62:0] != 0;
        OP_HALFAW: one = ef == ExpBias - 11'd1;
        OP_EVEN:   one = ef == ExpBias - 11'd1 && u[51:0] != 0;
        default:   one = 1'b0;
      endcase
      return one ? (sgn | OneBits) : sgn;
    end
    e = ef - ExpBias;
    fmask = {12'd0, MantMask} >> e;
    frac = u & fmask;
    if (frac == 0) return u;
    base = u & ~fmask;
    half = (fmask >> 1) + 64'd1;
    case (op)
      OP_FLOOR:  inc = sgn != 0;
      OP_CEIL:   inc = sgn == 0;
      OP_HALFAW: inc = frac >= half;
      OP_EVEN: begin
        lsb = (e == 0) ? 1'b1 : u[52 - e];
        inc = frac > half || (frac == half && lsb);
      end
      default:   inc = 1'b0;
    endcase
    return inc ? base + fmask + 64'd1 : base;
  endfunction

  function automatic logic [63:0] mk(logic s, int unsigned ef, logic [51:0] m);
    return {s, ef[10:0], m};
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] u;
    int unsigned k;
    u = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    // mostly exponents near the fraction boundary, where rounding matters
    if (k < 6) u[62:52] = 11'($urandom_range(1017, 1077));
    else if (k == 6) u[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'd0;
    else if (k == 7) begin
      // fractions a quarter above or below one half
      u[62:52] = 11'($urandom_range(1022, 1074));
      u[51:0]  = u[51:0] & ~(52'hf_ffff_ffff_ffff >> (u[62:52] - 1022));
      u[51:0]  = u[51:0] | ((52'h8_0000_0000_0000 >> (u[62:52] - 1022)) << 0);
    end
    return u;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fill the queue of pending transfers: directed corners, then random.
  initial begin
    round_req_t r;
    logic [63:0] corner[$];
    rst_ni = 1'b0;
    feed_done = 1'b0;
    corner = '{64'h0, 64'h8000_0000_0000_0000, mk(0, 1021, 52'h3333_3333_3333),
               mk(1, 1021, 52'h3333_3333_3333), mk(0, 1022, 0), mk(1, 1022, 0),
               mk(0, 1022, 1), mk(0, 0, 1), mk(1, 0, 52'hf_ffff_ffff_ffff),
               mk(0, 1024, 52'h4_0000_0000_0000), mk(0, 1024, 52'hc_0000_0000_0000),
               mk(1, 1023, 52'h8_0000_0000_0000), mk(0, 1074, 1),
               mk(0, 1074, 52'hf_ffff_ffff_ffff), mk(0, 1075, 1), 64'h7ff0_0000_0000_0000,
               64'hfff8_0000_0000_0001, 64'h7ff4_0000_0000_0000, 64'h3ff0_0000_0000_0000,
               64'hffff_ffff_ffff_ffff};
    foreach (corner[i]) begin
      r.opcode  = 3'(i % 8);
      r.operand = corner[i];
      pending_q.push_back(r);
    end
    for (int i = 0; i < 5; i++) begin
      r.opcode = 3'(i);
      r.operand = mk(1, 1022, 52'h8_0000_0000_0000);
      pending_q.push_back(r);
    end
    for (int i = 0; i < 500; i++) begin
      r.opcode  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
      r.operand = rand_operand();
      pending_q.push_back(r);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    feed_done = 1'b1;
  end

  // Driver: offer the head of the queue, hold it until the transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i        <= 1'b0;
      opcode_i       <= '0;
      operand_bits_i <= '0;
    end else begin
      if (valid_i && ready_o) begin
        sent_q.push_back('{opcode_i, operand_bits_i});
        rounded_q.push_back(round_integral(opcode_i, operand_bits_i));
        void'(pending_q.pop_front());
      end
      if (!valid_i || ready_o) begin
        // next item, if any, unless this cycle idles
        if (pending_q.size() > 0 && !hold_off &&
            (calm || $urandom_range(0, 99) >= 33)) begin
          valid_i        <= 1'b1;
          opcode_i       <= pending_q[0].opcode;
          operand_bits_i <= pending_q[0].operand;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random ready, compare each transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    round_req_t  src;
    if (!rst_ni) begin
      ready_i    <= 1'b0;
      n_mismatch <= 0;
      n_checked  <= 0;
    end else begin
      if (valid_o && ready_i) begin
        if (rounded_q.size() == 0) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) $display("unexpected result %h", result_bits_o);
        end else begin
          want = rounded_q.pop_front();
          src  = sent_q.pop_front();
          n_checked <= n_checked + 1;
          if (result_bits_o !== want) begin
            n_mismatch <= n_mismatch + 1;
            if (n_mismatch < 10)
              $display("mismatch op=%0d in=%h expected %h got %h",
                       src.opcode, src.operand, want, result_bits_o);
          end
        end
      end
      ready_i <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Phase control: a calm stretch, and one drain pause by the sender.
  initial begin
    calm = 1'b0;
    hold_off = 1'b0;
    wait (feed_done);
    wait (pending_q.size() < 400);
    @(posedge clk_i);
    hold_off = 1'b1;
    wait (rounded_q.size() == 0);
    @(posedge clk_i);
    hold_off = 1'b0;
    wait (pending_q.size() < 300);
    calm = 1'b1;
    wait (pending_q.size() < 200);
    calm = 1'b0;
    wait (pending_q.size() == 0 && !valid_i);
    wait (rounded_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("checked %0d rounded results over all modes, unused opcodes and corner operands",
             n_checked);
    if (n_mismatch == 0 && rounded_q.size() == 0) begin
      $display("fp64_round_to_integral_tb passed");
    end else begin
      $display("fp64_round_to_integral_tb failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("fp64_round_to_integral_tb failed");
    $finish;
  end
endmodule

// ----- fp64_round_to_integral.f -----
rtl/fp64rti_pkg.sv
rtl/fp64rti_core.sv
rtl/fp64_round_to_integral.sv
rtl/fp64rti_checker.sv
sim/fp64_round_to_integral_tb.sv
